### src/fcc_pkg.sv
// fcc_pkg: shared types and constants of the fir convolution / correlation unit
// holds item mode codes, register indexes, result width and the sequencer state type
// no dependencies
package fcc_pkg;

    localparam int SUM_BITS     = 38;
    localparam int CFG_IDX_BITS = 1;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_TAP    = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATCH_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORRELATE    = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

endpackage

### src/fir_convolution_correlation_unit.sv
// fir_convolution_correlation_unit: direct-form convolution / cross-correlation
// of a sample stream with a stored patch; depends on fcc_pkg and fcc_ram
//
// Usage
//   input channel (in_valid / in_stall): one word carries mode, tap_index and value.
//     load tap writes the tap store and gives no result; a sample gives one result;
//     finish gives P-1 flushed results, the final one with last set, then the delay
//     line reads as zero again. An unused mode is taken and dropped.
//   output channel (out_valid / out_stall): sum (Q8.30, 38 bits) and last.
//   cfg port: cfg_we writes patch_length (index 0) or correlate (index 1); write
//     only while the unit is idle.
// Timing
//   a sample walks the taps (P = taps in use) with one multiply-accumulate, one read of
//   the tap ram and the delay ram per cycle, then a multiply stage, an accumulate stage
//   and the output load; flushed results follow each other in the same way. The next
//   item is accepted only after the output load. A tap load or unused word is taken
//   without a stall.
//   in_stall is high while a sum is being computed; a finished word waits in the
//   output register while the next item is accepted and computed. If the receiver
//   stalls, the next sum waits in the accumulator until the output register frees.
// Reset
//   clears the control state and the delay line fill count (delay line reads as
//   zero), patch_length = 1, correlate = 0. Tap store contents are undefined until
//   written; no clearing pass is needed.
module fir_convolution_correlation_unit #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic [1:0]                                    mode,
    input  logic [$clog2(MAX_TAPS)-1:0]                   tap_index,
    input  logic signed [SAMPLE_BITS-1:0]                 value,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic signed [fcc_pkg::SUM_BITS-1:0]           sum,
    output logic                                          last,
    input  logic                                          cfg_we,
    input  logic [fcc_pkg::CFG_IDX_BITS-1:0]              cfg_index,
    input  logic [$clog2(MAX_TAPS+1)-1:0]                 cfg_data
);

    import fcc_pkg::*;

    localparam int AW   = $clog2(MAX_TAPS);
    localparam int PW   = $clog2(MAX_TAPS + 1);
    localparam int SB   = SAMPLE_BITS;
    localparam int ACCW = 2 * SB + AW;
    localparam int SATW = (ACCW > SUM_BITS) ? ACCW : SUM_BITS;

    state_t                 state_reg, state_next;
    logic [PW-1:0]          patch_length_reg, patch_length_next;
    logic                   correlate_reg, correlate_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [PW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          j_reg, j_next;
    logic                   flushing_reg, flushing_next;
    logic [AW-1:0]          flush_cnt_reg, flush_cnt_next;
    logic                   rd_v_reg, rd_last_reg, rd_dvalid_reg;
    logic                   mul_v_reg, mul_last_reg;
    logic signed [2*SB-1:0] mul_reg;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic                   done_reg, done_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic                   last_reg, last_next;

    logic                   in_accept;
    logic                   out_load;
    logic [PW-1:0]          p_eff;
    logic [AW-1:0]          p_minus1;
    logic [AW-1:0]          d_idx;
    logic [AW-1:0]          dl_raddr;
    logic                   d_valid;
    logic [AW-1:0]          wp_inc;
    logic [PW-1:0]          fill_inc;
    logic                   dl_we;
    logic [SB-1:0]          dl_wdata;
    logic [SB-1:0]          dl_rdata;
    logic                   tap_we;
    logic [SB-1:0]          tap_rdata;
    logic signed [SB-1:0]   smp_op;
    logic signed [SATW-1:0] acc_ext;
    logic signed [SUM_BITS-1:0] acc_sat;

    fcc_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_index),
        .wdata (value),
        .raddr (j_reg),
        .rdata (tap_rdata)
    );

    fcc_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (wp_inc),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign last      = last_reg;

    assign tap_we = in_accept && (mode_t'(mode) == MODE_TAP)
                    && ((AW + 1)'(tap_index) < (AW + 1)'(MAX_TAPS));

    // taps in use, zero reads as one and oversize as the full store
    always_comb
    begin
        if (patch_length_reg == '0)
        begin
            p_eff = PW'(1);
        end
        else if (patch_length_reg > PW'(MAX_TAPS))
        begin
            p_eff = PW'(MAX_TAPS);
        end
        else
        begin
            p_eff = patch_length_reg;
        end
    end

    assign p_minus1 = AW'(p_eff - PW'(1));
    assign d_idx    = correlate_reg ? (p_minus1 - j_reg) : j_reg;
    assign d_valid  = (PW'(d_idx) < fill_reg);

    // circular delay line, wp_reg holds the newest sample
    always_comb
    begin
        if (wp_reg >= d_idx)
        begin
            dl_raddr = wp_reg - d_idx;
        end
        else
        begin
            dl_raddr = AW'((AW + 1)'(wp_reg) + (AW + 1)'(MAX_TAPS) - (AW + 1)'(d_idx));
        end
    end

    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_inc = (fill_reg == PW'(MAX_TAPS)) ? fill_reg : fill_reg + PW'(1);

    assign smp_op  = rd_dvalid_reg ? signed'(dl_rdata) : '0;
    assign acc_ext = SATW'(acc_reg);

    always_comb
    begin
        if (acc_ext > SATW'(SUM_MAX))
        begin
            acc_sat = SUM_MAX;
        end
        else if (acc_ext < SATW'(SUM_MIN))
        begin
            acc_sat = SUM_MIN;
        end
        else
        begin
            acc_sat = SUM_BITS'(acc_ext);
        end
    end

    assign out_load = (state_reg == S_WAIT) && done_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next        = state_reg;
        patch_length_next = patch_length_reg;
        correlate_next    = correlate_reg;
        wp_next           = wp_reg;
        fill_next         = fill_reg;
        j_next            = j_reg;
        flushing_next     = flushing_reg;
        flush_cnt_next    = flush_cnt_reg;
        acc_next          = acc_reg;
        done_next         = done_reg;
        out_valid_next    = out_valid_reg && out_stall;
        sum_next          = sum_reg;
        last_next         = last_reg;
        dl_we             = 1'b0;
        dl_wdata          = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PATCH_LENGTH: patch_length_next = cfg_data;
                REG_CORRELATE:    correlate_next    = cfg_data[0];
                default:          ;
            endcase
        end

        if (mul_v_reg)
        begin
            acc_next = acc_reg + ACCW'(mul_reg);
            if (mul_last_reg)
            begin
                done_next = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (mode_t'(mode))
                        MODE_SAMPLE:
                        begin
                            dl_we      = 1'b1;
                            dl_wdata   = value;
                            wp_next    = wp_inc;
                            fill_next  = fill_inc;
                            j_next     = '0;
                            acc_next   = '0;
                            done_next  = 1'b0;
                            state_next = S_RUN;
                        end
                        MODE_FINISH:
                        begin
                            if (p_eff == PW'(1))
                            begin
                                fill_next = '0;
                            end
                            else
                            begin
                                dl_we          = 1'b1;
                                wp_next        = wp_inc;
                                fill_next      = fill_inc;
                                flushing_next  = 1'b1;
                                flush_cnt_next = p_minus1 - AW'(1);
                                j_next         = '0;
                                acc_next       = '0;
                                done_next      = 1'b0;
                                state_next     = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN:
            begin
                if (j_reg == p_minus1)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            S_WAIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = acc_sat;
                    last_next      = flushing_reg && (flush_cnt_reg == '0);
                    done_next      = 1'b0;
                    if (flushing_reg && (flush_cnt_reg != '0))
                    begin
                        // next flushed zero sample
                        dl_we          = 1'b1;
                        wp_next        = wp_inc;
                        fill_next      = fill_inc;
                        flush_cnt_next = flush_cnt_reg - AW'(1);
                        j_next         = '0;
                        acc_next       = '0;
                        state_next     = S_RUN;
                    end
                    else
                    begin
                        if (flushing_reg)
                        begin
                            fill_next     = '0;
                            flushing_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_length_reg <= PW'(1);
            correlate_reg    <= 1'b0;
            wp_reg           <= '0;
            fill_reg         <= '0;
            j_reg            <= '0;
            flushing_reg     <= 1'b0;
            flush_cnt_reg    <= '0;
            rd_v_reg         <= 1'b0;
            rd_last_reg      <= 1'b0;
            mul_v_reg        <= 1'b0;
            mul_last_reg     <= 1'b0;
            done_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            patch_length_reg <= patch_length_next;
            correlate_reg    <= correlate_next;
            wp_reg           <= wp_next;
            fill_reg         <= fill_next;
            j_reg            <= j_next;
            flushing_reg     <= flushing_next;
            flush_cnt_reg    <= flush_cnt_next;
            rd_v_reg         <= (state_reg == S_RUN);
            rd_last_reg      <= (state_reg == S_RUN) && (j_reg == p_minus1);
            mul_v_reg        <= rd_v_reg;
            mul_last_reg     <= rd_v_reg && rd_last_reg;
            done_reg         <= done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_dvalid_reg <= d_valid;
        mul_reg       <= signed'(tap_rdata) * smp_op;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        last_reg      <= last_next;
    end

    // input is taken only with the multiply-accumulate pipeline empty
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!rd_v_reg && !mul_v_reg && !done_reg))
        else $error("pipeline busy while accepting input");

    // a finished sum only waits in the wait state
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_WAIT))
        else $error("sum finished outside wait state");

    // the fill count never runs past the delay line depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PW'(MAX_TAPS))
        else $error("delay line fill count overflow");

    // after the final flushed word the delay line reads as zero
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (fill_reg == '0 && !flushing_reg && state_reg == S_IDLE))
        else $error("delay line not cleared after last word");

endmodule

### src/fcc_ram.sv
// fcc_ram: generic single-write, single-read synchronous ram with registered read data
// used for the tap store and the delay line; no dependencies
module fcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
